>>> src/upi_pkg.sv
// Shared types, widths and constants of the unicycle pose integrator.
package upi_pkg;

    // Angle and rotation setup.
    localparam int ANGLE_BITS  = 16;
    localparam int TRIG_STEPS  = 16;
    localparam int TAB_LEN     = 24;
    localparam int CORDIC_N    = (TRIG_STEPS > TAB_LEN) ? TAB_LEN : TRIG_STEPS;
    localparam int STEP_W      = $clog2(CORDIC_N);
    localparam int TAB_IW      = $clog2(TAB_LEN);
    localparam int CORDIC_GAIN = 652032874;

    // Field widths.
    localparam int SPEED_W = 24;
    localparam int YAW_W   = 24;
    localparam int DT_W    = 16;
    localparam int DIST_W  = 31;
    localparam int EXT_ANG_W = 16;
    localparam int POS_W   = 32;

    // Datapath widths.
    localparam int XY_W    = 34;
    localparam int TRIG_W  = 33;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 66;
    localparam int RATE_W  = SPEED_W + DT_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X       = 2'd0,
        CFG_START_Y       = 2'd1,
        CFG_START_HEADING = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_MOVE    = 1'b0,
        OP_PROJECT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MUL_COS_LO = 2'd0,
        MUL_COS_HI = 2'd1,
        MUL_SIN_LO = 2'd2,
        MUL_SIN_HI = 2'd3
    } t_mul_sel;

    // Arctangent of 2^-i as a 32-bit binary angle.
    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef struct packed {
        logic              load;
        logic              rot;
        logic [STEP_W-1:0] step;
        logic              trig;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              acc_first;
        logic              acc_add;
        logic              fin_x;
        logic              fin_y;
        logic              commit;
    } t_cmd;

endpackage

>>> src/upi_if.sv
// Handshake channels for input words and result words.
interface upi_in_if;
    import upi_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic signed [SPEED_W-1:0]   speed;
    logic signed [YAW_W-1:0]     yaw_rate;
    logic [DT_W-1:0]             step_time;
    logic [DIST_W-1:0]           distance;
    logic [EXT_ANG_W-1:0]        direction;
    modport source (output valid, opcode, speed, yaw_rate, step_time, distance, direction,
                    input ready);
    modport sink   (input valid, opcode, speed, yaw_rate, step_time, distance, direction,
                    output ready);
endinterface

interface upi_out_if;
    import upi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   out_x;
    logic signed [POS_W-1:0]   out_y;
    logic [EXT_ANG_W-1:0]      out_heading;
    modport source (output valid, out_x, out_y, out_heading, input ready);
    modport sink   (input valid, out_x, out_y, out_heading, output ready);
endinterface

>>> src/upi_ctrl.sv
// Controller that sequences rotation, multiply and commit for one word.
module upi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upi_pkg::t_cmd o_cmd
);
    import upi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_TRIG,
        S_MUL,
        S_COMMIT
    } t_state;

    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_N - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(5);

    t_state            r_state;
    logic [STEP_W-1:0] r_cnt;
    logic              r_out_valid;
    logic              slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.step    = r_cnt;
        o_cmd.mul_sel = MUL_COS_LO;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
            end
            S_MUL: begin
                // Two partial products per coordinate, each accumulated in the cycle after it is formed.
                case (r_cnt)
                    STEP_W'(0): begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_COS_LO;
                    end
                    STEP_W'(1): begin
                        o_cmd.mul_en    = 1'b1;
                        o_cmd.mul_sel   = MUL_COS_HI;
                        o_cmd.acc_first = 1'b1;
                    end
                    STEP_W'(2): begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_SIN_LO;
                        o_cmd.acc_add = 1'b1;
                    end
                    STEP_W'(3): begin
                        o_cmd.mul_en    = 1'b1;
                        o_cmd.mul_sel   = MUL_SIN_HI;
                        o_cmd.acc_first = 1'b1;
                        o_cmd.fin_x     = 1'b1;
                    end
                    STEP_W'(4): begin
                        o_cmd.acc_add = 1'b1;
                    end
                    STEP_W'(5): begin
                        o_cmd.fin_y = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_COMMIT: begin
                o_cmd.commit = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_cnt == ROT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_TRIG;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TRIG: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_COMMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_accept_starts_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ROT && r_cnt == '0))
        else $error("accepted word did not start rotation at step zero");

    a_rot_count_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_cnt == ROT_LAST) |=> (r_state == S_TRIG))
        else $error("rotation did not end after the last step");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit would overwrite an untaken result");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented after commit");
`endif

endmodule

>>> src/upi_dp.sv
// Datapath: pose registers, shift-add sine/cosine, shared multiplier and saturation.
module upi_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  upi_pkg::t_cmd                         i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [upi_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [upi_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_opcode,
    input  logic signed [upi_pkg::SPEED_W-1:0]    i_speed,
    input  logic signed [upi_pkg::YAW_W-1:0]      i_yaw_rate,
    input  logic [upi_pkg::DT_W-1:0]              i_step_time,
    input  logic [upi_pkg::DIST_W-1:0]            i_distance,
    input  logic [upi_pkg::EXT_ANG_W-1:0]         i_direction,
    output logic signed [upi_pkg::POS_W-1:0]      o_out_x,
    output logic signed [upi_pkg::POS_W-1:0]      o_out_y,
    output logic [upi_pkg::EXT_ANG_W-1:0]         o_out_heading
);
    import upi_pkg::*;

    localparam int SUM_W  = ACC_W - 30 + 1;
    localparam int FRAC_W = 32 - ANGLE_BITS;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< 29;
    localparam logic signed [SUM_W-1:0] POS_MAX  = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] POS_MIN  = ~POS_MAX;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] res;
        if (v > POS_MAX) begin
            res = POS_W'(POS_MAX);
        end else if (v < POS_MIN) begin
            res = POS_W'(POS_MIN);
        end else begin
            res = POS_W'(v);
        end
        return res;
    endfunction

    // Pose state.
    logic signed [POS_W-1:0]      r_pose_x;
    logic signed [POS_W-1:0]      r_pose_y;
    logic [ANGLE_BITS-1:0]        r_pose_h;

    // Captured word.
    logic                         r_opcode;
    logic signed [SPEED_W-1:0]    r_speed;
    logic signed [YAW_W-1:0]      r_yaw_rate;
    logic [DT_W-1:0]              r_step_time;
    logic [DIST_W-1:0]            r_distance;

    // Rotation.
    logic signed [XY_W-1:0]       r_cx;
    logic signed [XY_W-1:0]       r_cy;
    logic signed [XY_W-1:0]       r_cz;
    logic [1:0]                   r_quad;
    logic signed [TRIG_W-1:0]     r_cos;
    logic signed [TRIG_W-1:0]     r_sin;

    // Multiply and accumulate.
    logic signed [MUL_A_W-1:0]    r_mul_a;
    logic [ANGLE_BITS-1:0]        r_inc;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [POS_W-1:0]      r_sum_x;
    logic signed [POS_W-1:0]      r_sum_y;

    // Result.
    logic signed [POS_W-1:0]      r_out_x;
    logic signed [POS_W-1:0]      r_out_y;
    logic [EXT_ANG_W-1:0]         r_out_h;

    logic [31:0]                  angle;
    logic [31:0]                  angle_rnd;
    logic [1:0]                   quad;
    logic [31:0]                  resid;
    logic signed [XY_W-1:0]       x_sh;
    logic signed [XY_W-1:0]       y_sh;
    logic signed [XY_W-1:0]       atan_v;
    logic signed [XY_W-1:0]       cos_full;
    logic signed [XY_W-1:0]       sin_full;
    logic signed [RATE_W-1:0]     sp_dt;
    logic signed [RATE_W-1:0]     yr_dt;
    logic signed [SPEED_W:0]      dist_q;
    logic signed [TRIG_W-1:0]     trig_op;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [SUM_W-1:0]      delta;
    logic signed [SUM_W-1:0]      pose_sel;
    logic signed [SUM_W-1:0]      sum;
    logic [ANGLE_BITS-1:0]        head_next;
    logic [31:0]                  head_wide;
    logic [31:0]                  cfg_head;

    // Quadrant reduction leaves a residual in [-1/8, 1/8) turn.
    assign angle     = (i_opcode == OP_PROJECT) ? {i_direction, 16'b0}
                                                : {r_pose_h, FRAC_W'(0)};
    assign angle_rnd = angle + 32'h2000_0000;
    assign quad      = angle_rnd[31:30];
    assign resid     = angle - {quad, 30'b0};

    assign x_sh   = r_cx >>> i_cmd.step;
    assign y_sh   = r_cy >>> i_cmd.step;
    assign atan_v = XY_W'(ATAN_TAB[TAB_IW'(i_cmd.step)]);

    always_comb begin
        case (r_quad)
            2'd0: begin
                cos_full = r_cx;
                sin_full = r_cy;
            end
            2'd1: begin
                cos_full = -r_cy;
                sin_full = r_cx;
            end
            2'd2: begin
                cos_full = -r_cx;
                sin_full = -r_cy;
            end
            default: begin
                cos_full = r_cy;
                sin_full = -r_cx;
            end
        endcase
    end

    assign sp_dt  = r_speed * $signed({1'b0, r_step_time});
    assign yr_dt  = r_yaw_rate * $signed({1'b0, r_step_time});
    assign dist_q = sp_dt[RATE_W-1:16];

    assign trig_op = (i_cmd.mul_sel == MUL_SIN_LO || i_cmd.mul_sel == MUL_SIN_HI)
                     ? r_sin : r_cos;

    always_comb begin
        case (i_cmd.mul_sel) inside
            MUL_COS_LO, MUL_SIN_LO: mul_b = $signed({1'b0, trig_op[15:0]});
            default:                mul_b = trig_op[TRIG_W-1:16];
        endcase
    end

    assign delta    = SUM_W'($signed(r_acc[ACC_W-1:30]));
    assign pose_sel = i_cmd.fin_y ? SUM_W'(r_pose_y) : SUM_W'(r_pose_x);
    assign sum      = pose_sel + delta;

    assign head_next = (r_opcode == OP_PROJECT) ? r_pose_h : r_pose_h + r_inc;
    assign head_wide = {head_next, FRAC_W'(0)};
    assign cfg_head  = {i_cfg_data[EXT_ANG_W-1:0], 16'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_pose_h <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X:       r_pose_x <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_START_Y:       r_pose_y <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_START_HEADING: r_pose_h <= cfg_head[31 -: ANGLE_BITS];
                default: begin
                end
            endcase
        end else if (i_cmd.commit) begin
            r_pose_h <= head_next;
            if (r_opcode == OP_MOVE) begin
                r_pose_x <= r_sum_x;
                r_pose_y <= r_sum_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode    <= i_opcode;
            r_speed     <= i_speed;
            r_yaw_rate  <= i_yaw_rate;
            r_step_time <= i_step_time;
            r_distance  <= i_distance;
            r_cx        <= XY_W'(CORDIC_GAIN);
            r_cy        <= '0;
            r_cz        <= XY_W'($signed(resid));
            r_quad      <= quad;
        end else if (i_cmd.rot) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - y_sh;
                r_cy <= r_cy + x_sh;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + y_sh;
                r_cy <= r_cy - x_sh;
                r_cz <= r_cz + atan_v;
            end
        end

        if (i_cmd.trig) begin
            r_cos <= TRIG_W'(cos_full);
            r_sin <= TRIG_W'(sin_full);
        end

        // The captured word holds still until the next load, so these track it freely.
        r_mul_a <= (r_opcode == OP_PROJECT) ? MUL_A_W'($signed({1'b0, r_distance}))
                                            : MUL_A_W'(dist_q);
        r_inc   <= yr_dt[FRAC_W +: ANGLE_BITS];

        if (i_cmd.mul_en) begin
            r_prod <= r_mul_a * mul_b;
        end
        if (i_cmd.acc_first) begin
            r_acc <= ACC_W'(r_prod) + RND_HALF;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (ACC_W'(r_prod) <<< 16);
        end
        if (i_cmd.fin_x) begin
            r_sum_x <= sat_pos(sum);
        end
        if (i_cmd.fin_y) begin
            r_sum_y <= sat_pos(sum);
        end

        if (i_cmd.commit) begin
            r_out_x <= r_sum_x;
            r_out_y <= r_sum_y;
            r_out_h <= head_wide[31:16];
        end
    end

    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_heading = r_out_h;

endmodule

>>> src/unicycle_pose_integrator_core.sv
// Top level of the unicycle pose integrator: controller, datapath and channel wiring.
//
//   Channel   Direction  Contents
//   i_item    in         opcode, speed, yaw_rate, step_time, distance, direction
//   o_result  out        out_x, out_y, out_heading
//   i_cfg_*   in         write of start_x, start_y, start_heading (index 0..2)
//
// A word is taken only in the idle state and then runs, until the next acceptance,
// through an accept state, the 16 rotation steps of the sine/cosine unit, a
// latch of the quadrant-corrected pair, the shared 32x17 multiplier and
// accumulator, and a commit state. The result register frees the input
// side: a new word is taken while the previous result waits; commit waits only
// when that result is still untaken. Reset is synchronous and clears the pose.
module unicycle_pose_integrator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    upi_in_if.sink                            i_item,
    upi_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [upi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [upi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import upi_pkg::*;

    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    upi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    upi_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_item.opcode),
        .i_speed       (i_item.speed),
        .i_yaw_rate    (i_item.yaw_rate),
        .i_step_time   (i_item.step_time),
        .i_distance    (i_item.distance),
        .i_direction   (i_item.direction),
        .o_out_x       (o_result.out_x),
        .o_out_y       (o_result.out_y),
        .o_out_heading (o_result.out_heading)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule
